// ===== rtl/core/prt_pkg.sv =====
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types, codes and reset values of the pending reply table.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam int MODE_W   = 2;
    localparam int CMD_W    = 16;
    localparam int RES_W    = 8;
    localparam int LIFE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int EXP_W    = 5;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LIFETIME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DROP     = 8'd1;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 8'd10;
    localparam logic [CMD_W-1:0]  DROP_RESET     = 16'd25601;
    localparam logic [EXP_W-1:0]  EXP_MAX        = 5'd31;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [RES_W-1:0]  result;
        logic [LIFE_W-1:0] life;
    } rec_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CMD_W-1:0]  command;
        logic [RES_W-1:0]  result_code;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RES_W-1:0]    found_result;
        logic [EXP_W-1:0]    expired_count;
    } rsp_t;

    typedef struct packed {
        logic [LIFE_W-1:0] entry_lifetime;
        logic [CMD_W-1:0]  drop_command;
    } cfg_t;

endpackage

// ===== rtl/core/prt_table_mem.sv =====
// ----------------------------------------------------------------------------
// prt_table_mem
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prt_table_mem #(
    parameter int DEPTH = prt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  prt_pkg::rec_t            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output prt_pkg::rec_t            rdata
);
    import prt_pkg::*;

    rec_t mem [DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/prt_engine.sv =====
// ----------------------------------------------------------------------------
// prt_engine
// Sequencer: add, scan-and-compact for get, age-and-compact for tick.
// ----------------------------------------------------------------------------
module prt_engine #(
    parameter int DEPTH = prt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  prt_pkg::cfg_t cfg,
    input  logic          req_valid,
    output logic          req_ready,
    input  prt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output prt_pkg::rsp_t rsp
);
    import prt_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_TICK  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    req_t          req_reg, req_next;
    rsp_t          rsp_reg, rsp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0] didx_reg, didx_next;
    logic          dv_reg, dv_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    rec_t          mem_wdata;
    logic [IW-1:0] mem_raddr;
    rec_t          mem_rdata;
    logic          issue;
    logic [LIFE_W-1:0] life_dec;

    prt_table_mem #(.DEPTH(DEPTH)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign life_dec = mem_rdata.life - LIFE_W'(1);

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        rsp_next    = rsp_reg;
        cnt_next    = cnt_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        didx_next   = rd_ptr_reg[IW-1:0];
        dv_next     = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = wr_ptr_reg[IW-1:0];
        mem_wdata   = mem_rdata;
        mem_raddr   = rd_ptr_reg[IW-1:0];
        issue       = 1'b0;

        if (state_reg == ST_SCAN || state_reg == ST_SHIFT || state_reg == ST_TICK) begin
            issue = (rd_ptr_reg < cnt_reg);
            dv_next = issue;
            if (issue) begin
                rd_ptr_next = rd_ptr_reg + CW'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    req_next = req;
                    rsp_next = '{status: STATUS_IGNORED, found_result: '0, expired_count: '0};
                    state_next = ST_DONE;
                    rd_ptr_next = CW'(1);
                    wr_ptr_next = '0;
                    mem_raddr = '0;
                    didx_next = '0;
                    case (req.mode)
                        MODE_ADD: begin
                            if (req.command == '0 || req.command == cfg.drop_command) begin
                                rsp_next.status = STATUS_IGNORED;
                            end else if (cnt_reg == CW'(DEPTH)) begin
                                rsp_next.status = STATUS_FULL;
                            end else begin
                                mem_we = 1'b1;
                                mem_waddr = cnt_reg[IW-1:0];
                                mem_wdata = '{command: req.command, result: req.result_code,
                                              life: cfg.entry_lifetime};
                                cnt_next = cnt_reg + CW'(1);
                                rsp_next.status = STATUS_OK;
                            end
                        end
                        MODE_GET: begin
                            rsp_next.status = STATUS_MISSING;
                            if (cnt_reg != '0) begin
                                dv_next = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        MODE_TICK: begin
                            rsp_next.status = STATUS_OK;
                            if (cnt_reg != '0) begin
                                dv_next = 1'b1;
                                state_next = ST_TICK;
                            end
                        end
                        default: begin
                            rsp_next.status = STATUS_IGNORED;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (dv_reg && mem_rdata.command == req_reg.command) begin
                    rsp_next.status = STATUS_OK;
                    rsp_next.found_result = mem_rdata.result;
                    wr_ptr_next = CW'(didx_reg);
                    state_next = ST_SHIFT;
                end else if (!issue) begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (dv_reg) begin
                    mem_we = 1'b1;
                    mem_wdata = mem_rdata;
                    wr_ptr_next = wr_ptr_reg + CW'(1);
                end
                if (!issue) begin
                    cnt_next = cnt_reg - CW'(1);
                    state_next = ST_DONE;
                end
            end
            ST_TICK: begin
                if (dv_reg) begin
                    if (life_dec == '0) begin
                        if (rsp_reg.expired_count != EXP_MAX) begin
                            rsp_next.expired_count = rsp_reg.expired_count + EXP_W'(1);
                        end
                    end else begin
                        mem_we = 1'b1;
                        mem_wdata = '{command: mem_rdata.command, result: mem_rdata.result,
                                      life: life_dec};
                        wr_ptr_next = wr_ptr_reg + CW'(1);
                    end
                end
                if (!issue) begin
                    cnt_next = wr_ptr_next;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            dv_reg     <= 1'b0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            dv_reg     <= dv_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
        req_reg  <= req_next;
        rsp_reg  <= rsp_next;
        didx_reg <= didx_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);
    assign rsp       = rsp_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("fill count above table depth");

    a_idle_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !dv_reg)
        else $error("read data pending outside a sweep");

    a_wr_behind_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_reg && (state_reg == ST_SHIFT || state_reg == ST_TICK))
            |-> wr_ptr_reg <= CW'(didx_reg))
        else $error("compaction write overtakes read");

    a_shift_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SHIFT |-> cnt_reg != '0)
        else $error("removal from empty table");

    a_rd_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_SHIFT || state_reg == ST_TICK)
            |-> rd_ptr_reg <= cnt_reg)
        else $error("sweep read past fill count");

endmodule

// ===== rtl/core/pending_reply_table_with_lifetime_top.sv =====
// ----------------------------------------------------------------------------
// pending_reply_table_with_lifetime_top
// Age-ordered reply table with per-record lifetime, stream in and out.
//
//   channel  | direction | word contents
//   s_       | in        | tuser: mode; tdata: command, result_code
//   m_       | out       | tuser: status; tdata: found_result, expired_count
//   cfg_     | in        | index 0 entry_lifetime, index 1 drop_command
//
// Add, ignored word and unused mode go straight to the response. Get and
// tick sweep the record memory through its single read port, one entry a
// cycle up to the fill count, with compaction behind the read.
// Synchronous active-low reset empties the table at once (fill count).
// A finished word waits in the output register while the next one is taken.
// ----------------------------------------------------------------------------
module pending_reply_table_with_lifetime_top #(
    parameter int TABLE_DEPTH = prt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // command[15:0], result_code[23:16]
    input  logic [prt_pkg::MODE_W-1:0]       s_tuser,   // mode[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // found_result[7:0], expired_count[12:8]
    output logic [prt_pkg::STATUS_W-1:0]     m_tuser,   // status[1:0]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [prt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import prt_pkg::*;

    cfg_t cfg_reg, cfg_next;
    req_t req;
    rsp_t rsp, out_reg;
    logic rsp_valid, rsp_ready;
    logic m_tvalid_reg, m_tvalid_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_LIFETIME: cfg_next.entry_lifetime = cfg_data[LIFE_W-1:0];
                REG_DROP:     cfg_next.drop_command   = cfg_data[CMD_W-1:0];
                default: ;
            endcase
        end
    end

    assign req = '{mode: s_tuser, command: s_tdata[15:0], result_code: s_tdata[23:16]};

    prt_engine #(.DEPTH(TABLE_DEPTH)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    assign rsp_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (rsp_ready) begin
            m_tvalid_next = rsp_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= '{entry_lifetime: LIFETIME_RESET, drop_command: DROP_RESET};
            m_tvalid_reg <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (rsp_valid && rsp_ready) begin
            out_reg <= rsp;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = out_reg.status;
    assign m_tdata   = {3'b000, out_reg.expired_count, out_reg.found_result};

endmodule
